// ===== rtl/bflcr_pkg.sv =====
// Package with shared types and constants of the buffer frame lookup unit.
package bflcr_pkg;

  localparam int unsigned FileW = 16;
  localparam int unsigned PageW = 24;
  localparam int unsigned FrameW = 6;

  localparam logic [1:0] OpRead = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRelFile = 2'd2;
  localparam logic [1:0] OpRelAll = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StLookup,
    StSweep,
    StRelease,
    StOut
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the input beat
    logic lookup;     // tag match and first-choice allocation
    logic sweep_step; // one clock-hand step
    logic rel_step;   // examine one frame for release
    logic rel_close;  // load the closing release result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_release;
    logic alloc_done;  // lookup resolved without sweep
    logic sweep_done;  // current sweep step found a victim
    logic rel_emit;    // current release frame produces a write-back
    logic rel_last;    // current release frame is the final frame
  } dp_sts_t;

endpackage

// ===== rtl/buffer_frame_lookup_clock_replace_unit.sv =====
// Top level of the buffer pool frame table with clock replacement.
//
// The unit takes one beat at a time on the slave side and answers on the master side.
// A read or write access is resolved by the lookup on a hit or when a never-allocated
// or discarded frame is available; otherwise the clock sweep steps the hand frame by
// frame until it finds an unreferenced victim. A release walks all Frames entries, one
// per cycle, and holds on each selected dirty frame until its write-back beat is taken,
// then sends a closing beat with tlast-style last set. A new input beat is accepted
// only once the final result beat of the previous one has been taken. Tags are
// undefined after reset and are read only for occupied frames.
module buffer_frame_lookup_clock_replace_unit import bflcr_pkg::*; #(
  parameter int unsigned Frames = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // operation[1:0], file_id[17:2], page_id[41:18]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // frame[5:0], hit[6], writeback_valid[7],
                                     // writeback_file[23:8], writeback_page[47:24]
  output logic        m_axis_tlast
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [FrameW-1:0] frame;
  logic hit, wbv, last;
  logic [FileW-1:0] wbf;
  logic [PageW-1:0] wbp;

  bflcr_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_last_i(last), .cmd_o(cmd), .sts_i(sts)
  );

  bflcr_datapath #(.Frames(Frames)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .sts_o(sts),
    .op_i(s_axis_tdata[1:0]), .file_i(s_axis_tdata[17:2]), .page_i(s_axis_tdata[41:18]),
    .frame_o(frame), .hit_o(hit), .wbv_o(wbv), .wbf_o(wbf), .wbp_o(wbp), .last_o(last)
  );

  assign m_axis_tdata = {wbp, wbf, wbv, hit, frame};
  assign m_axis_tlast = last;

endmodule

// ===== rtl/bflcr_datapath.sv =====
// Datapath of the frame table: tags, status bits, clock hand and result register.
module bflcr_datapath import bflcr_pkg::*; #(
  parameter int unsigned Frames = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [1:0]        op_i,
  input  logic [FileW-1:0]  file_i,
  input  logic [PageW-1:0]  page_i,
  output logic [FrameW-1:0] frame_o,
  output logic              hit_o,
  output logic              wbv_o,
  output logic [FileW-1:0]  wbf_o,
  output logic [PageW-1:0]  wbp_o,
  output logic              last_o
);

  localparam int unsigned IdxW = (Frames > 1) ? $clog2(Frames) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Frames - 1);

  logic [FileW-1:0] tag_file_q [Frames];
  logic [PageW-1:0] tag_page_q [Frames];
  logic [Frames-1:0] occ_q, ever_q, ref_q, dirty_q;
  logic [IdxW-1:0] hand_q, idx_q;
  logic [1:0] op_q;
  logic [FileW-1:0] file_q;
  logic [PageW-1:0] page_q;

  logic [FrameW-1:0] frame_q;
  logic hit_q, wbv_q, last_q;
  logic [FileW-1:0] wbf_q;
  logic [PageW-1:0] wbp_q;

  logic [Frames-1:0] match;
  logic hit_any, free_any, disc_any;
  logic [IdxW-1:0] hit_idx, free_idx, disc_idx;

  always_comb begin
    hit_any = 1'b0;
    free_any = 1'b0;
    disc_any = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    disc_idx = '0;
    for (int i = Frames - 1; i >= 0; i--) begin
      match[i] = occ_q[i] && tag_file_q[i] == file_q && tag_page_q[i] == page_q;
      if (match[i]) begin
        hit_any = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!ever_q[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
      if (!occ_q[i]) begin
        disc_any = 1'b1;
        disc_idx = IdxW'(i);
      end
    end
  end

  logic rel_sel;
  assign rel_sel = occ_q[idx_q] && (op_q == OpRelAll || tag_file_q[idx_q] == file_q);

  assign sts_o.is_release = op_q[1];
  assign sts_o.alloc_done = hit_any || free_any || disc_any;
  assign sts_o.sweep_done = !ref_q[hand_q];
  assign sts_o.rel_emit = rel_sel && dirty_q[idx_q];
  assign sts_o.rel_last = idx_q == LastIdx;

  logic [IdxW-1:0] hand_nxt;
  assign hand_nxt = (hand_q == LastIdx) ? '0 : hand_q + 1'b1;

  // Allocate on a miss: never-allocated frame, then discarded one, then sweep victim.
  logic do_alloc;
  logic [IdxW-1:0] alloc_idx;
  always_comb begin
    do_alloc = 1'b0;
    alloc_idx = hand_q;
    if (cmd_i.lookup && !hit_any && (free_any || disc_any)) begin
      do_alloc = 1'b1;
      alloc_idx = free_any ? free_idx : disc_idx;
    end else if (cmd_i.sweep_step && !ref_q[hand_q]) begin
      do_alloc = 1'b1;
      alloc_idx = hand_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= op_i;
      file_q <= file_i;
      page_q <= page_i;
    end
    if (do_alloc) begin
      tag_file_q[alloc_idx] <= file_q;
      tag_page_q[alloc_idx] <= page_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      ever_q <= '0;
      ref_q <= '0;
      dirty_q <= '0;
      hand_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        idx_q <= '0;
      end
      if (cmd_i.lookup && hit_any) begin
        ref_q[hit_idx] <= 1'b1;
        if (op_q == OpWrite) begin
          dirty_q[hit_idx] <= 1'b1;
        end
      end
      if (cmd_i.sweep_step) begin
        hand_q <= hand_nxt;
        if (ref_q[hand_q]) begin
          ref_q[hand_q] <= 1'b0;
        end
      end
      if (do_alloc) begin
        occ_q[alloc_idx] <= 1'b1;
        ever_q[alloc_idx] <= 1'b1;
        ref_q[alloc_idx] <= 1'b1;
        dirty_q[alloc_idx] <= op_q == OpWrite;
      end
      if (cmd_i.rel_step) begin
        if (rel_sel) begin
          occ_q[idx_q] <= 1'b0;
          ref_q[idx_q] <= 1'b0;
          dirty_q[idx_q] <= 1'b0;
        end
        if (idx_q != LastIdx) begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup && sts_o.alloc_done) begin
      frame_q <= FrameW'(hit_any ? hit_idx : alloc_idx);
      hit_q <= hit_any;
      wbv_q <= !hit_any && occ_q[alloc_idx] && dirty_q[alloc_idx];
      wbf_q <= (!hit_any && occ_q[alloc_idx] && dirty_q[alloc_idx]) ?
               tag_file_q[alloc_idx] : '0;
      wbp_q <= (!hit_any && occ_q[alloc_idx] && dirty_q[alloc_idx]) ?
               tag_page_q[alloc_idx] : '0;
      last_q <= 1'b1;
    end else if (do_alloc) begin
      frame_q <= FrameW'(alloc_idx);
      hit_q <= 1'b0;
      wbv_q <= occ_q[alloc_idx] && dirty_q[alloc_idx];
      wbf_q <= (occ_q[alloc_idx] && dirty_q[alloc_idx]) ? tag_file_q[alloc_idx] : '0;
      wbp_q <= (occ_q[alloc_idx] && dirty_q[alloc_idx]) ? tag_page_q[alloc_idx] : '0;
      last_q <= 1'b1;
    end else if (cmd_i.rel_step && sts_o.rel_emit) begin
      frame_q <= FrameW'(idx_q);
      hit_q <= 1'b0;
      wbv_q <= 1'b1;
      wbf_q <= tag_file_q[idx_q];
      wbp_q <= tag_page_q[idx_q];
      last_q <= 1'b0;
    end else if (cmd_i.rel_close) begin
      frame_q <= '0;
      hit_q <= 1'b0;
      wbv_q <= 1'b0;
      wbf_q <= '0;
      wbp_q <= '0;
      last_q <= 1'b1;
    end
  end

  assign frame_o = frame_q;
  assign hit_o = hit_q;
  assign wbv_o = wbv_q;
  assign wbf_o = wbf_q;
  assign wbp_o = wbp_q;
  assign last_o = last_q;

  // A sweep never runs while a never-allocated or discarded frame exists.
  a_sweep_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep_step |-> (&ever_q && &occ_q))
    else $error("clock sweep with a free frame");

  // Every allocated frame ends up occupied and referenced.
  a_alloc_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_alloc |=> (occ_q[$past(alloc_idx)] && ref_q[$past(alloc_idx)]))
    else $error("allocated frame not marked");

  // At most one frame holds a given tag.
  a_unique_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.lookup |-> $onehot0(match))
    else $error("duplicate tag in frame table");

endmodule

// ===== rtl/bflcr_ctrl.sv =====
// Controller state machine of the frame table.
module bflcr_ctrl import bflcr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  logic    out_last_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_e state_q, state_d;
  logic rel_more_q, rel_more_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rel_more_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rel_more_q <= rel_more_d;
    end
  end

  always_comb begin
    state_d = state_q;
    rel_more_d = rel_more_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StLookup;
        end
      end
      StLookup: begin
        if (sts_i.is_release) begin
          state_d = StRelease;
        end else begin
          cmd_o.lookup = 1'b1;
          state_d = sts_i.alloc_done ? StOut : StSweep;
        end
      end
      StSweep: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = StOut;
        end
      end
      StRelease: begin
        if (sts_i.rel_emit) begin
          cmd_o.rel_step = 1'b1;
          rel_more_d = !sts_i.rel_last;
          state_d = StOut;
        end else if (sts_i.rel_last) begin
          cmd_o.rel_step = 1'b1;
          cmd_o.rel_close = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.rel_step = 1'b1;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (out_last_i) begin
            state_d = StIdle;
          end else if (rel_more_q) begin
            state_d = StRelease;
          end else begin
            cmd_o.rel_close = 1'b1;
            state_d = StOut;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  a_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken while result pending");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_last_i) |=> state_q == StIdle)
    else $error("no return to idle after last beat");

  a_sweep_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSweep && sts_i.sweep_done) |=> out_valid_o)
    else $error("sweep victim not presented");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the buffer pool frame table with clock replacement.
module tb;
  import bflcr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumFrames = 16;

  typedef struct packed {
    logic [PageW-1:0]  wb_page;
    logic [FileW-1:0]  wb_file;
    logic              wb_valid;
    logic              hit;
    logic [FrameW-1:0] frame;
    logic              last;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // operation[1:0], file_id[17:2], page_id[41:18]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // frame, hit, writeback_valid, writeback_file, page
  logic        m_axis_tlast;

  buffer_frame_lookup_clock_replace_unit #(.Frames(NumFrames)) dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the frame table.
  logic [FileW-1:0] shadow_file [NumFrames];
  logic [PageW-1:0] shadow_page [NumFrames];
  logic [NumFrames-1:0] shadow_occ, shadow_ever, shadow_ref, shadow_dirty;
  int unsigned shadow_hand;

  frame_result_t pending_results[$];
  int unsigned   error_count;
  int unsigned   send_idle_pct, recv_idle_pct;

  // A small pool of files and pages so that hits and releases actually happen.
  logic [FileW-1:0] hot_files [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001};

  function automatic frame_result_t make_result(int unsigned fr, bit h, bit wv,
                                                logic [FileW-1:0] f, logic [PageW-1:0] p,
                                                bit l);
    frame_result_t r;
    r.frame = fr[FrameW-1:0];
    r.hit = h;
    r.wb_valid = wv;
    r.wb_file = f;
    r.wb_page = p;
    r.last = l;
    return r;
  endfunction

  // Append one expected beat to the tail of the queue.
  function automatic void queue_result(frame_result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic int unsigned choose_victim();
    for (int i = 0; i < NumFrames; i++) if (!shadow_ever[i]) return i;
    for (int i = 0; i < NumFrames; i++) if (!shadow_occ[i]) return i;
    // Clock sweep: clear reference bits until an unreferenced frame turns up.
    while (shadow_ref[shadow_hand]) begin
      shadow_ref[shadow_hand] = 1'b0;
      shadow_hand = (shadow_hand + 1) % NumFrames;
    end
    choose_victim = shadow_hand;
    shadow_hand = (shadow_hand + 1) % NumFrames;
  endfunction

  // Update the shadow table for one input beat and queue its results.
  function automatic void predict_frame_results(logic [1:0] op, logic [FileW-1:0] f,
                                                logic [PageW-1:0] p);
    int unsigned v;
    if (op == OpRelFile || op == OpRelAll) begin
      for (int i = 0; i < NumFrames; i++) begin
        if (!shadow_occ[i] || (op == OpRelFile && shadow_file[i] != f)) continue;
        if (shadow_dirty[i])
          queue_result(make_result(i, 0, 1, shadow_file[i], shadow_page[i], 0));
        shadow_occ[i] = 0;
        shadow_ref[i] = 0;
        shadow_dirty[i] = 0;
      end
      queue_result(make_result(0, 0, 0, '0, '0, 1));
      return;
    end
    for (int i = 0; i < NumFrames; i++) begin
      if (shadow_occ[i] && shadow_file[i] == f && shadow_page[i] == p) begin
        shadow_ref[i] = 1;
        if (op == OpWrite) shadow_dirty[i] = 1;
        queue_result(make_result(i, 1, 0, '0, '0, 1));
        return;
      end
    end
    v = choose_victim();
    if (shadow_occ[v] && shadow_dirty[v])
      queue_result(make_result(v, 0, 1, shadow_file[v], shadow_page[v], 1));
    else
      queue_result(make_result(v, 0, 0, '0, '0, 1));
    shadow_file[v] = f;
    shadow_page[v] = p;
    shadow_occ[v] = 1;
    shadow_ever[v] = 1;
    shadow_ref[v] = 1;
    shadow_dirty[v] = (op == OpWrite);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Send one beat, with a random idle gap in front of it. Valid stays high after
  // the accepting edge and is dropped only while idling.
  task automatic send_access(logic [1:0] op, logic [FileW-1:0] f, logic [PageW-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, p, f, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frame_results(op, f, p);
  endtask

  // Receiver: random back-pressure and field-by-field comparison.
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[5:0] != want.frame)
            report_mismatch("frame", m_axis_tdata[5:0], want.frame);
          if (m_axis_tdata[6] != want.hit) report_mismatch("hit", m_axis_tdata[6], want.hit);
          if (m_axis_tdata[7] != want.wb_valid)
            report_mismatch("writeback_valid", m_axis_tdata[7], want.wb_valid);
          if (m_axis_tdata[23:8] != want.wb_file)
            report_mismatch("writeback_file", m_axis_tdata[23:8], want.wb_file);
          if (m_axis_tdata[47:24] != want.wb_page)
            report_mismatch("writeback_page", m_axis_tdata[47:24], want.wb_page);
          if (m_axis_tlast != want.last) report_mismatch("last", m_axis_tlast, want.last);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed();
    // Fill every frame, mixing reads and writes and extreme field values.
    for (int i = 0; i < NumFrames; i++)
      send_access(i[0] ? OpWrite : OpRead, (i < 8) ? 16'hFFFF : 16'h0000,
                  (i == 0) ? 24'hFFFFFF : 24'(i));
    send_access(OpWrite, 16'hFFFF, 24'hFFFFFF);    // hit, now dirty
    send_access(OpRead, 16'h5555, 24'hAAAAAA);     // sweep clears all references
    send_access(OpWrite, 16'hAAAA, 24'h555555);    // sweep evicts a dirty frame
    send_access(OpRelFile, 16'hFFFF, 24'hFFFFFF);  // page field ignored
    send_access(OpRead, 16'h0001, 24'h000001);     // reuses a discarded frame
    send_access(OpRelFile, 16'h7777, 24'h0);       // releases nothing
    send_access(OpRelAll, 16'h1234, 24'h123456);   // file field ignored
  endtask

  task automatic test_random(int unsigned count);
    logic [1:0] op;
    logic [FileW-1:0] f;
    logic [PageW-1:0] p;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(99) < 90) ? 2'($urandom_range(1)) : 2'($urandom_range(3, 2));
      f = ($urandom_range(9) < 8) ? hot_files[$urandom_range(3)] : 16'($urandom);
      p = ($urandom_range(9) < 8) ? 24'($urandom_range(23)) : 24'($urandom);
      send_access(op, f, p);
    end
  endtask

  initial begin
    shadow_occ = '0;
    shadow_ever = '0;
    shadow_ref = '0;
    shadow_dirty = '0;
    shadow_hand = 0;
    error_count = 0;
    send_idle_pct = 21;
    recv_idle_pct = 84;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(150);
    send_idle_pct = 84;
    recv_idle_pct = 21;
    test_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/bflcr_pkg.sv
rtl/bflcr_datapath.sv
rtl/bflcr_ctrl.sv
rtl/buffer_frame_lookup_clock_replace_unit.sv
sim/tb.sv
